@@ rtl/nmfb_pkg.sv @@
// Package for the named mailbox byte FIFO bank: word types, command and
// status codes, sequencer states and default sizes. No dependencies.
package nmfb_pkg;

  localparam int unsigned DefMailboxes    = 16;
  localparam int unsigned DefBufferBytes  = 256;
  localparam int unsigned DefProcessSlots = 64;
  localparam logic [6:0]  CountMax        = 7'd127;

  typedef enum logic [2:0] {
    CMD_OPEN    = 3'd0,
    CMD_CLOSE   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RECV    = 3'd3,
    CMD_RELEASE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD       = 3'd3,
    ST_NOT_OPEN  = 3'd4,
    ST_NONE_FREE = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MATCH,
    S_FREE,
    S_RELEASE,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  mailbox_index;
    logic [63:0] name_key;
    logic [5:0]  process_slot;
    logic [7:0]  send_byte;
    logic        final_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] mailbox_id;
    logic [7:0] recv_byte;
    logic       message_done;
  } out_word_t;

endpackage

@@ rtl/named_mailbox_byte_fifo_bank.sv @@
// Top level of the named mailbox byte FIFO bank: sequencer, mailbox
// descriptor registers and the shared byte memory. Depends on nmfb_pkg.
//
// One input word is taken while the block is idle and the output register
// is free; it is decoded and then handled by a sequencer that visits one
// mailbox per cycle through a single shared compare unit. Send, close and
// errors go from decode straight to the done state; receive first passes
// a read state for the registered memory read. Open walks the mailboxes
// for a name match and then for a free one; release walks all MAILBOXES
// once. The result waits in an output register; the next word is accepted
// once that register has been taken or in the same cycle it is taken. The
// byte memory needs no clearing after reset since an entry is only read
// after it has been written.
module named_mailbox_byte_fifo_bank #(
  parameter int unsigned MAILBOXES     = nmfb_pkg::DefMailboxes,
  parameter int unsigned BUFFER_BYTES  = nmfb_pkg::DefBufferBytes,
  parameter int unsigned PROCESS_SLOTS = nmfb_pkg::DefProcessSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nmfb_pkg::in_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nmfb_pkg::out_word_t out_data_o
);
  import nmfb_pkg::*;

  localparam int unsigned MbW  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
  localparam int unsigned PtrW = $clog2(BUFFER_BYTES);
  localparam int unsigned FilW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned MemD = MAILBOXES * BUFFER_BYTES;
  localparam int unsigned MemW = $clog2(MemD);
  localparam int unsigned CntW = $clog2(MAILBOXES + 1);

  // Mailbox descriptors.
  logic [PtrW-1:0] head_q [MAILBOXES];
  logic [PtrW-1:0] tail_q [MAILBOXES];
  logic [FilW-1:0] fill_q [MAILBOXES];
  logic [6:0]      count_q[MAILBOXES];
  logic [63:0]     users_q[MAILBOXES];
  logic [63:0]     name_q [MAILBOXES];

  logic [7:0] mem [MemD];
  logic [7:0] rd_data_q;

  state_e    state_q, state_d;
  in_word_t  req_q;
  out_word_t res_q, res_d;
  logic      out_valid_q, out_valid_d;
  logic [CntW-1:0] walk_q, walk_d;

  logic [MbW-1:0] box;
  logic           in_accept;
  logic           out_free;
  logic           box_live;
  logic [63:0]    slot_bit;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // The shared unit looks at one mailbox: the walk counter during a
  // search, the requested index otherwise.
  always_comb begin
    if (state_q == S_MATCH || state_q == S_FREE || state_q == S_RELEASE) begin
      box = walk_q[MbW-1:0];
    end else begin
      box = req_q.mailbox_index[MbW-1:0];
    end
  end
  assign box_live = (users_q[box] != 64'd0);
  assign slot_bit = 64'd1 << req_q.process_slot;

  // Descriptor update requests from the sequencer.
  typedef struct packed {
    logic free_box;
    logic claim;
    logic bump;
    logic drop;
    logic push;
    logic pop;
    logic clr_bit;
  } upd_t;
  upd_t upd;

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    walk_d      = walk_q;
    upd         = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_d.status       = ST_OK;
        res_d.mailbox_id   = req_q.mailbox_index[3:0];
        res_d.recv_byte    = 8'd0;
        res_d.message_done = 1'b0;
        walk_d             = '0;
        state_d            = S_DONE;
        if (req_q.command == CMD_OPEN || req_q.command == CMD_RELEASE) begin
          if (32'(req_q.process_slot) >= PROCESS_SLOTS) begin
            res_d.status = ST_BAD;
            if (req_q.command == CMD_OPEN) begin
              res_d.mailbox_id = 4'd0;
            end
          end else if (req_q.command == CMD_OPEN) begin
            state_d = S_MATCH;
          end else begin
            state_d = S_RELEASE;
          end
        end else if (req_q.command == CMD_CLOSE || req_q.command == CMD_SEND ||
                     req_q.command == CMD_RECV) begin
          if (32'(req_q.mailbox_index) >= MAILBOXES) begin
            res_d.status = ST_BAD;
          end else if (!box_live) begin
            res_d.status = ST_NOT_OPEN;
          end else if (req_q.command == CMD_CLOSE) begin
            if (count_q[box] <= 7'd1) begin
              upd.free_box = 1'b1;
            end else begin
              upd.drop = 1'b1;
            end
          end else if (req_q.command == CMD_SEND) begin
            if (32'(fill_q[box]) >= BUFFER_BYTES) begin
              res_d.status = ST_FULL;
            end else begin
              upd.push           = 1'b1;
              res_d.message_done = req_q.final_byte;
            end
          end else begin
            if (fill_q[box] == '0) begin
              res_d.status = ST_EMPTY;
            end else begin
              upd.pop            = 1'b1;
              res_d.message_done = req_q.final_byte;
              state_d            = S_READ;
            end
          end
        end else begin
          res_d.status = ST_BAD;
        end
      end
      S_MATCH: begin
        if (box_live && name_q[box] == req_q.name_key) begin
          upd.bump         = 1'b1;
          res_d.mailbox_id = 4'(box);
          state_d          = S_DONE;
        end else if (32'(walk_q) == MAILBOXES - 1) begin
          walk_d  = '0;
          state_d = S_FREE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_FREE: begin
        if (!box_live) begin
          upd.claim        = 1'b1;
          upd.bump         = 1'b1;
          res_d.mailbox_id = 4'(box);
          state_d          = S_DONE;
        end else if (32'(walk_q) == MAILBOXES - 1) begin
          res_d.status     = ST_NONE_FREE;
          res_d.mailbox_id = 4'd0;
          state_d          = S_DONE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_RELEASE: begin
        upd.clr_bit = 1'b1;
        if (32'(walk_q) == MAILBOXES - 1) begin
          state_d = S_DONE;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      S_READ: begin
        res_d.recv_byte = rd_data_q;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      walk_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      walk_q      <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_accept) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAILBOXES; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        fill_q[i]  <= '0;
        count_q[i] <= '0;
        users_q[i] <= '0;
        name_q[i]  <= '0;
      end
    end else begin
      if (upd.free_box) begin
        head_q[box]  <= '0;
        tail_q[box]  <= '0;
        fill_q[box]  <= '0;
        count_q[box] <= '0;
        users_q[box] <= '0;
        name_q[box]  <= '0;
      end
      if (upd.drop) begin
        count_q[box] <= count_q[box] - 7'd1;
      end
      if (upd.bump) begin
        if (upd.claim) begin
          // A claimed mailbox starts empty with one reference.
          head_q[box]  <= '0;
          tail_q[box]  <= '0;
          fill_q[box]  <= '0;
          count_q[box] <= 7'd1;
          users_q[box] <= slot_bit;
          name_q[box]  <= req_q.name_key;
        end else begin
          if (count_q[box] < CountMax) begin
            count_q[box] <= count_q[box] + 7'd1;
          end
          users_q[box] <= users_q[box] | slot_bit;
        end
      end
      if (upd.push) begin
        tail_q[box] <= (32'(tail_q[box]) + 1 >= BUFFER_BYTES) ? '0 : tail_q[box] + 1'b1;
        fill_q[box] <= fill_q[box] + 1'b1;
      end
      if (upd.pop) begin
        head_q[box] <= (32'(head_q[box]) + 1 >= BUFFER_BYTES) ? '0 : head_q[box] + 1'b1;
        fill_q[box] <= fill_q[box] - 1'b1;
      end
      if (upd.clr_bit && (users_q[box] & slot_bit) != 64'd0) begin
        if ((users_q[box] & ~slot_bit) == 64'd0) begin
          head_q[box]  <= '0;
          tail_q[box]  <= '0;
          fill_q[box]  <= '0;
          count_q[box] <= '0;
          users_q[box] <= '0;
          name_q[box]  <= '0;
        end else begin
          users_q[box] <= users_q[box] & ~slot_bit;
        end
      end
    end
  end

  // Byte memory: one write port for send, one registered read for receive.
  logic [MemW-1:0] wr_addr, rd_addr;
  assign wr_addr = MemW'(32'(box) * BUFFER_BYTES + 32'(tail_q[box]));
  assign rd_addr = MemW'(32'(box) * BUFFER_BYTES + 32'(head_q[box]));

  always_ff @(posedge clk_i) begin
    if (upd.push) begin
      mem[wr_addr] <= req_q.send_byte;
    end
    rd_data_q <= mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> state_q == S_IDLE)
    else $error("word accepted while busy");
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_DECODE)
    else $error("accepted word not decoded");
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({upd.free_box, upd.drop, upd.push, upd.pop, upd.clr_bit, upd.bump}))
    else $error("conflicting descriptor updates");
`endif

endmodule
